// File: rtl/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg
// shared types, codes and key selection for the task dispatch scheduler
// ----------------------------------------------------------------------------
package tds_pkg;

   typedef logic [23:0] time_type;

   // one job record as it sits in the job memory
   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio;
      logic [15:0] remaining;
      logic [23:0] response;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   // policy codes
   localparam logic [2:0] POL_FCFS = 3'd0;
   localparam logic [2:0] POL_SJF  = 3'd1;
   localparam logic [2:0] POL_LJF  = 3'd2;
   localparam logic [2:0] POL_RR   = 3'd3;
   localparam logic [2:0] POL_PRIO = 3'd4;
   localparam logic [2:0] POL_SRTF = 3'd5;

   // opcodes
   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_DISPATCH = 2'd1;
   localparam logic [1:0] OP_REWIND   = 2'd2;

   // status codes
   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_SLICE = 2'd1;
   localparam logic [1:0] STS_DONE  = 2'd2;
   localparam logic [1:0] STS_FULL  = 2'd3;

   // register indexes
   localparam logic REG_POLICY  = 1'b0;
   localparam logic REG_QUANTUM = 1'b1;

   // selection key, smaller wins
   function automatic logic [15:0] sel_key(input logic [2:0] pol, input job_type j);
      logic [15:0] k;
      case (pol)
         POL_SJF:  k = j.burst;
         POL_LJF:  k = ~j.burst;
         POL_PRIO: k = {8'd0, j.prio};
         POL_SRTF: k = j.remaining;
         default:  k = j.arrival;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/tds_ram.sv
// ----------------------------------------------------------------------------
// tds_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/task_dispatch_scheduler_top.sv
// ----------------------------------------------------------------------------
// task_dispatch_scheduler_top
// single-processor job dispatcher over a table of jobs held in memory
// ----------------------------------------------------------------------------
// usage:
//  - req channel (valid/ready) carries one command beat: load a job, dispatch
//    the next slice, or rewind progress. rsp channel returns one beat each.
//  - csr port writes policy (index 0) and quantum (index 1); the user must
//    write them only while idle, the block does not enforce this.
//  - one command at a time. per command the sequencer does:
//    load / rewind: a restore sweep over every loaded job in the job memory
//    table full, all done, unused opcode: straight to S_EMIT
//    dispatch, non round robin: one pick scan, or when no job is ready an
//    earliest-arrival scan and a second pick scan
//    dispatch, round robin: every admission is one scan over the job memory,
//    so many arrivals at once mean many scans; a fifo head check passes
//    through S_DROP_F and S_DROP_J, and S_DROP_C for a loaded index
//  - the scan reads one job record per cycle from the job memory through
//    its registered read port
//  - reset empties the table, clears time and the fifo, policy fcfs,
//    quantum 2. no memory clearing pass is needed.
//  - a finished beat waits in the rsp register; the next command is taken
//    meanwhile and its beat is held until the rsp register frees up
// ----------------------------------------------------------------------------
module task_dispatch_scheduler_top #(
   parameter int MAX_PROCS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [15:0]       req_arrival_time,
   input  logic [15:0]       req_burst_time,
   input  logic [7:0]        req_prio_level,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [3:0]        rsp_proc_index,
   output tds_pkg::time_type rsp_slice_start,
   output logic [15:0]       rsp_slice_length,
   output logic              rsp_finished,
   output tds_pkg::time_type rsp_response_time,
   output tds_pkg::time_type rsp_turnaround_time,
   output tds_pkg::time_type rsp_waiting_time,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [15:0]       csr_wr_data
);

   import tds_pkg::*;

   localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PROCS);
   localparam logic [IW-1:0] IDX_LAST = IW'(MAX_PROCS - 1);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_CLEAR   = 11'b000_0000_0010,
      S_PICK    = 11'b000_0000_0100,
      S_JUMP    = 11'b000_0000_1000,
      S_ADMIT   = 11'b000_0001_0000,
      S_DROP_F  = 11'b000_0010_0000,
      S_DROP_J  = 11'b000_0100_0000,
      S_DROP_C  = 11'b000_1000_0000,
      S_SLICE   = 11'b001_0000_0000,
      S_REQUEUE = 11'b010_0000_0000,
      S_EMIT    = 11'b100_0000_0000
   } state_type;

   // control state
   state_type      state_ff, state_in;
   logic [CW-1:0]  entry_cnt_ff, entry_cnt_in;
   logic [CW-1:0]  done_cnt_ff, done_cnt_in;
   time_type       now_ff, now_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [IW-1:0]  tail_ff, tail_in;
   logic [CW-1:0]  used_ff, used_in;
   logic [MAX_PROCS-1:0] started_ff, started_in;
   logic [MAX_PROCS-1:0] admitted_ff, admitted_in;
   logic [2:0]     policy_ff, policy_in;
   logic [15:0]    quantum_ff, quantum_in;
   logic [CW-1:0]  scan_addr_ff, scan_addr_in;
   logic           scan_pend_ff, scan_pend_in;
   logic           found_ff, found_in;
   logic           retry_ff, retry_in;
   logic           rr_phase_ff, rr_phase_in;
   logic           admit_post_ff, admit_post_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [IW-1:0]  scan_idx_ff, scan_idx_in;
   logic [IW-1:0]  best_idx_ff, best_idx_in;
   job_type        best_rec_ff, best_rec_in;
   logic [IW-1:0]  cur_idx_ff, cur_idx_in;
   job_type        cur_rec_ff, cur_rec_in;
   logic [IW-1:0]  fifo_idx_ff, fifo_idx_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [3:0]     res_index_ff, res_index_in;
   time_type       res_start_ff, res_start_in;
   logic [15:0]    res_length_ff, res_length_in;
   logic           res_finished_ff, res_finished_in;
   time_type       res_resp_ff, res_resp_in;
   time_type       res_tat_ff, res_tat_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [3:0]     rsp_index_ff, rsp_index_in;
   time_type       rsp_start_ff, rsp_start_in;
   logic [15:0]    rsp_length_ff, rsp_length_in;
   logic           rsp_finished_ff, rsp_finished_in;
   time_type       rsp_resp_ff, rsp_resp_in;
   time_type       rsp_tat_ff, rsp_tat_in;
   time_type       rsp_wait_ff, rsp_wait_in;

   // memory ports
   logic           job_we;
   logic [IW-1:0]  job_waddr, job_raddr;
   job_type        job_wdata, job_rdata;
   logic [JOB_W-1:0] job_rbits;
   logic           fifo_we;
   logic [IW-1:0]  fifo_waddr, fifo_raddr;
   logic [IW-1:0]  fifo_wdata, fifo_rdata;

   // scan evaluation
   logic [2:0]     pol;
   logic           rr_mode;
   logic           only_new;
   logic [2:0]     key_pol;
   logic [15:0]    key_new, key_best;
   logic           elig, better, take;
   logic           scan_issue, scan_done;
   logic           scan_restart;
   logic           do_push;
   logic [IW-1:0]  push_idx;

   // slice arithmetic
   logic [15:0]    q_eff, slice_len, new_rem;
   time_type       slice_resp, new_now;

   tds_ram #(.WIDTH(JOB_W), .DEPTH(MAX_PROCS)) u_job_ram (
      .clock   (clock),
      .wr_en   (job_we),
      .wr_addr (job_waddr),
      .wr_data (job_wdata),
      .rd_addr (job_raddr),
      .rd_data (job_rbits)
   );
   assign job_rdata = job_type'(job_rbits);

   tds_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_waddr),
      .wr_data (fifo_wdata),
      .rd_addr (fifo_raddr),
      .rd_data (fifo_rdata)
   );

   // unused policy codes behave as fcfs
   assign pol     = (policy_ff > POL_SRTF) ? POL_FCFS : policy_ff;
   assign rr_mode = (pol == POL_RR);

   // admission scans only look at jobs not yet in the round robin fifo
   assign only_new = (state_ff == S_ADMIT) || ((state_ff == S_JUMP) && rr_mode);
   assign key_pol  = (state_ff == S_ADMIT) ? POL_FCFS : pol;
   assign key_new  = sel_key(key_pol, job_rdata);
   assign key_best = sel_key(key_pol, best_rec_ff);

   always_comb begin
      elig = (job_rdata.remaining != 16'd0) && !(only_new && admitted_ff[scan_idx_ff]);
      if (state_ff == S_JUMP) begin
         // earliest arrival among unfinished jobs (in round robin, only those not yet admitted)
         better = !found_ff || (job_rdata.arrival < best_rec_ff.arrival);
      end else begin
         elig   = elig && ({8'd0, job_rdata.arrival} <= now_ff);
         better = !found_ff || (key_new < key_best) ||
                  ((key_new == key_best) && (job_rdata.arrival < best_rec_ff.arrival));
      end
   end
   assign take = scan_pend_ff && elig && better;

   // one record read per cycle, evaluated in the cycle after its read is issued
   assign scan_issue = (scan_addr_ff < entry_cnt_ff);
   assign scan_done  = !scan_issue && !scan_pend_ff;

   // slice length and timing
   assign q_eff = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;
   always_comb begin
      if (rr_mode) begin
         slice_len = (q_eff > cur_rec_ff.remaining) ? cur_rec_ff.remaining : q_eff;
      end else if (pol == POL_SRTF) begin
         slice_len = 16'd1;
      end else begin
         slice_len = cur_rec_ff.remaining;
      end
   end
   assign new_rem    = cur_rec_ff.remaining - slice_len;
   assign new_now    = now_ff + {8'd0, slice_len};
   assign slice_resp = started_ff[cur_idx_ff] ? cur_rec_ff.response
                                              : now_ff - {8'd0, cur_rec_ff.arrival};

   assign fifo_raddr = head_ff;
   assign fifo_waddr = tail_ff;
   assign fifo_wdata = push_idx;
   assign fifo_we    = do_push && (used_ff < CNT_MAX);

   always_comb begin
      state_in        = state_ff;
      entry_cnt_in    = entry_cnt_ff;
      done_cnt_in     = done_cnt_ff;
      now_in          = now_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      used_in         = used_ff;
      started_in      = started_ff;
      admitted_in     = admitted_ff;
      policy_in       = policy_ff;
      quantum_in      = quantum_ff;
      scan_addr_in    = scan_addr_ff;
      scan_pend_in    = 1'b0;
      scan_idx_in     = scan_idx_ff;
      found_in        = found_ff;
      retry_in        = retry_ff;
      rr_phase_in     = rr_phase_ff;
      admit_post_in   = admit_post_ff;
      rsp_valid_in    = rsp_valid_ff;
      best_idx_in     = best_idx_ff;
      best_rec_in     = best_rec_ff;
      cur_idx_in      = cur_idx_ff;
      cur_rec_in      = cur_rec_ff;
      fifo_idx_in     = fifo_idx_ff;
      res_status_in   = res_status_ff;
      res_index_in    = res_index_ff;
      res_start_in    = res_start_ff;
      res_length_in   = res_length_ff;
      res_finished_in = res_finished_ff;
      res_resp_in     = res_resp_ff;
      res_tat_in      = res_tat_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_finished_in = rsp_finished_ff;
      rsp_resp_in     = rsp_resp_ff;
      rsp_tat_in      = rsp_tat_ff;
      rsp_wait_in     = rsp_wait_ff;
      job_we          = 1'b0;
      job_waddr       = scan_idx_ff;
      job_wdata       = job_rdata;
      job_raddr       = scan_addr_ff[IW-1:0];
      do_push         = 1'b0;
      push_idx        = best_idx_ff;
      scan_restart    = 1'b0;

      // csr writes
      if (csr_wr_en) begin
         case (csr_index)
            REG_POLICY:  policy_in  = csr_wr_data[2:0];
            REG_QUANTUM: quantum_in = csr_wr_data;
            default:     ;
         endcase
      end

      // rsp register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // shared scan datapath
      if ((state_ff == S_CLEAR) || (state_ff == S_PICK) || (state_ff == S_JUMP) ||
          (state_ff == S_ADMIT)) begin
         if (scan_issue) begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
         scan_pend_in = scan_issue;
         scan_idx_in  = scan_addr_ff[IW-1:0];
         if (take) begin
            found_in    = 1'b1;
            best_idx_in = scan_idx_ff;
            best_rec_in = job_rdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_status_in   = STS_OK;
               res_index_in    = '0;
               res_start_in    = '0;
               res_length_in   = '0;
               res_finished_in = 1'b0;
               res_resp_in     = '0;
               res_tat_in      = '0;
               case (req_opcode)
                  OP_LOAD: begin
                     if (entry_cnt_ff >= CNT_MAX) begin
                        res_status_in = STS_FULL;
                        state_in      = S_EMIT;
                     end else begin
                        job_we              = 1'b1;
                        job_waddr           = entry_cnt_ff[IW-1:0];
                        job_wdata.arrival   = req_arrival_time;
                        job_wdata.burst     = (req_burst_time == 16'd0) ? 16'd1 : req_burst_time;
                        job_wdata.prio      = req_prio_level;
                        job_wdata.remaining = job_wdata.burst;
                        job_wdata.response  = '0;
                        entry_cnt_in        = entry_cnt_ff + 1'b1;
                        started_in          = '0;
                        admitted_in         = '0;
                        done_cnt_in         = '0;
                        now_in              = '0;
                        head_in             = '0;
                        tail_in             = '0;
                        used_in             = '0;
                        state_in            = S_CLEAR;
                        scan_restart        = 1'b1;
                     end
                  end
                  OP_DISPATCH: begin
                     if (done_cnt_ff >= entry_cnt_ff) begin
                        res_status_in = STS_DONE;
                        state_in      = S_EMIT;
                     end else if (rr_mode) begin
                        admit_post_in = 1'b0;
                        rr_phase_in   = 1'b0;
                        state_in      = S_ADMIT;
                        scan_restart  = 1'b1;
                     end else begin
                        retry_in     = 1'b0;
                        state_in     = S_PICK;
                        scan_restart = 1'b1;
                     end
                  end
                  OP_REWIND: begin
                     started_in   = '0;
                     admitted_in  = '0;
                     done_cnt_in  = '0;
                     now_in       = '0;
                     head_in      = '0;
                     tail_in      = '0;
                     used_in      = '0;
                     state_in     = S_CLEAR;
                     scan_restart = 1'b1;
                  end
                  default: state_in = S_EMIT;
               endcase
            end
         end

         S_CLEAR: begin
            // restore remaining time of every loaded job
            if (scan_pend_ff) begin
               job_we              = 1'b1;
               job_waddr           = scan_idx_ff;
               job_wdata           = job_rdata;
               job_wdata.remaining = job_rdata.burst;
            end
            if (scan_done) begin
               state_in = S_EMIT;
            end
         end

         S_PICK: begin
            if (scan_done) begin
               if (found_ff) begin
                  cur_idx_in = best_idx_ff;
                  cur_rec_in = best_rec_ff;
                  state_in   = S_SLICE;
               end else if (!retry_ff) begin
                  state_in     = S_JUMP;
                  scan_restart = 1'b1;
               end else begin
                  res_status_in = STS_DONE;
                  state_in      = S_EMIT;
               end
            end
         end

         S_JUMP: begin
            if (scan_done) begin
               if (found_ff && ({8'd0, best_rec_ff.arrival} > now_ff)) begin
                  now_in = {8'd0, best_rec_ff.arrival};
               end
               scan_restart = 1'b1;
               if (rr_mode) begin
                  admit_post_in = 1'b0;
                  rr_phase_in   = 1'b1;
                  state_in      = S_ADMIT;
               end else begin
                  retry_in = 1'b1;
                  state_in = S_PICK;
               end
            end
         end

         S_ADMIT: begin
            if (scan_done) begin
               if (found_ff) begin
                  admitted_in[best_idx_ff] = 1'b1;
                  do_push      = 1'b1;
                  push_idx     = best_idx_ff;
                  scan_restart = 1'b1;
               end else if (admit_post_ff) begin
                  state_in = S_REQUEUE;
               end else begin
                  state_in = S_DROP_F;
               end
            end
         end

         S_DROP_F: begin
            if (used_ff == '0) begin
               if (!rr_phase_ff) begin
                  state_in     = S_JUMP;
                  scan_restart = 1'b1;
               end else begin
                  res_status_in = STS_DONE;
                  state_in      = S_EMIT;
               end
            end else begin
               state_in = S_DROP_J;
            end
         end

         S_DROP_J: begin
            if (CW'(fifo_rdata) >= entry_cnt_ff) begin
               head_in  = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
               used_in  = used_ff - 1'b1;
               state_in = S_DROP_F;
            end else begin
               job_raddr   = fifo_rdata;
               fifo_idx_in = fifo_rdata;
               state_in    = S_DROP_C;
            end
         end

         S_DROP_C: begin
            // pop either way: a finished head is dropped, a live head is taken
            head_in = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
            used_in = used_ff - 1'b1;
            if (job_rdata.remaining == 16'd0) begin
               state_in = S_DROP_F;
            end else begin
               cur_idx_in = fifo_idx_ff;
               cur_rec_in = job_rdata;
               state_in   = S_SLICE;
            end
         end

         S_SLICE: begin
            job_we              = 1'b1;
            job_waddr           = cur_idx_ff;
            job_wdata           = cur_rec_ff;
            job_wdata.remaining = new_rem;
            job_wdata.response  = slice_resp;
            cur_rec_in          = job_wdata;
            started_in[cur_idx_ff] = 1'b1;
            now_in              = new_now;
            res_status_in       = STS_SLICE;
            res_index_in        = 4'(cur_idx_ff);
            res_start_in        = now_ff;
            res_length_in       = slice_len;
            if (new_rem == 16'd0) begin
               done_cnt_in     = done_cnt_ff + 1'b1;
               res_finished_in = 1'b1;
               res_resp_in     = slice_resp;
               res_tat_in      = new_now - {8'd0, cur_rec_ff.arrival};
            end
            if (rr_mode) begin
               admit_post_in = 1'b1;
               state_in      = S_ADMIT;
               scan_restart  = 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end

         S_REQUEUE: begin
            // preempted job goes behind the arrivals of its own slice
            if (cur_rec_ff.remaining != 16'd0) begin
               do_push  = 1'b1;
               push_idx = cur_idx_ff;
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_index_in    = res_index_ff;
               rsp_start_in    = res_start_ff;
               rsp_length_in   = res_length_ff;
               rsp_finished_in = res_finished_ff;
               rsp_resp_in     = res_resp_ff;
               rsp_tat_in      = res_tat_ff;
               rsp_wait_in     = res_finished_ff ? res_tat_ff - {8'd0, cur_rec_ff.burst}
                                                 : '0;
               state_in        = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      if (do_push && (used_ff < CNT_MAX)) begin
         tail_in = (tail_ff == IDX_LAST) ? '0 : tail_ff + 1'b1;
         used_in = used_ff + 1'b1;
      end

      if (scan_restart) begin
         scan_addr_in = '0;
         scan_pend_in = 1'b0;
         found_in     = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         entry_cnt_ff  <= '0;
         done_cnt_ff   <= '0;
         now_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         used_ff       <= '0;
         started_ff    <= '0;
         admitted_ff   <= '0;
         policy_ff     <= POL_FCFS;
         quantum_ff    <= 16'd2;
         scan_addr_ff  <= '0;
         scan_pend_ff  <= 1'b0;
         found_ff      <= 1'b0;
         retry_ff      <= 1'b0;
         rr_phase_ff   <= 1'b0;
         admit_post_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         entry_cnt_ff  <= entry_cnt_in;
         done_cnt_ff   <= done_cnt_in;
         now_ff        <= now_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         used_ff       <= used_in;
         started_ff    <= started_in;
         admitted_ff   <= admitted_in;
         policy_ff     <= policy_in;
         quantum_ff    <= quantum_in;
         scan_addr_ff  <= scan_addr_in;
         scan_pend_ff  <= scan_pend_in;
         found_ff      <= found_in;
         retry_ff      <= retry_in;
         rr_phase_ff   <= rr_phase_in;
         admit_post_ff <= admit_post_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff     <= scan_idx_in;
      best_idx_ff     <= best_idx_in;
      best_rec_ff     <= best_rec_in;
      cur_idx_ff      <= cur_idx_in;
      cur_rec_ff      <= cur_rec_in;
      fifo_idx_ff     <= fifo_idx_in;
      res_status_ff   <= res_status_in;
      res_index_ff    <= res_index_in;
      res_start_ff    <= res_start_in;
      res_length_ff   <= res_length_in;
      res_finished_ff <= res_finished_in;
      res_resp_ff     <= res_resp_in;
      res_tat_ff      <= res_tat_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_start_ff    <= rsp_start_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_finished_ff <= rsp_finished_in;
      rsp_resp_ff     <= rsp_resp_in;
      rsp_tat_ff      <= rsp_tat_in;
      rsp_wait_ff     <= rsp_wait_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_proc_index      = rsp_index_ff;
   assign rsp_slice_start     = rsp_start_ff;
   assign rsp_slice_length    = rsp_length_ff;
   assign rsp_finished        = rsp_finished_ff;
   assign rsp_response_time   = rsp_resp_ff;
   assign rsp_turnaround_time = rsp_tat_ff;
   assign rsp_waiting_time    = rsp_wait_ff;

   // checks
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_MAX)
      else $error("round robin fifo overfilled");

   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      done_cnt_ff <= entry_cnt_ff)
      else $error("more jobs done than loaded");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_EMIT))
      else $error("result beat overwrote a stalled rsp beat");

endmodule

// File: test/task_dispatch_scheduler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_dispatch_scheduler_top_test
// self-checking bench for the job dispatcher: a scoreboard predicts every
// response beat from the commands taken and the register settings, and
// compares each response field by field while both channels idle at random
// ----------------------------------------------------------------------------
module task_dispatch_scheduler_top_test;
   import tds_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  proc_index;
      logic [23:0] slice_start;
      logic [15:0] slice_length;
      logic        finished;
      logic [23:0] response_time;
      logic [23:0] turnaround_time;
      logic [23:0] waiting_time;
   } slice_beat_type;

   class dispatch_scoreboard;
      localparam int NJOBS = 16;

      // job table and run progress
      logic [15:0] arr_tab[NJOBS];
      logic [15:0] burst_tab[NJOBS];
      logic [7:0]  prio_tab[NJOBS];
      logic [15:0] left_tab[NJOBS];
      logic [23:0] resp_tab[NJOBS];
      bit          started[NJOBS];
      bit          admitted[NJOBS];
      int          job_count;
      int          done_count;
      logic [23:0] now_t;
      int          rr_q[NJOBS];
      int          rr_head, rr_tail, rr_used;
      logic [2:0]  policy;
      logic [15:0] quantum;

      slice_beat_type expected_beats[$];
      int             errors;

      function new();
         job_count = 0;
         policy    = POL_FCFS;
         quantum   = 16'd2;
         errors    = 0;
         clear_progress();
      endfunction

      function void clear_progress();
         for (int i = 0; i < NJOBS; i++) begin
            if (i < job_count) left_tab[i] = burst_tab[i];
            started[i]  = 0;
            admitted[i] = 0;
         end
         done_count = 0;
         now_t      = '0;
         rr_head    = 0;
         rr_tail    = 0;
         rr_used    = 0;
      endfunction

      function int job_key(int i, logic [2:0] pol);
         case (pol)
            POL_SJF:  return burst_tab[i];
            POL_LJF:  return 16'hFFFF - burst_tab[i];
            POL_PRIO: return prio_tab[i];
            POL_SRTF: return left_tab[i];
            default:  return arr_tab[i];
         endcase
      endfunction

      function int pick_job(logic [2:0] pol, bit only_new);
         int best;
         best = -1;
         for (int i = 0; i < job_count; i++) begin
            if (left_tab[i] == 0 || 24'(arr_tab[i]) > now_t) continue;
            if (only_new && admitted[i]) continue;
            if (best < 0) best = i;
            else if (job_key(i, pol) < job_key(best, pol) ||
                     (job_key(i, pol) == job_key(best, pol) && arr_tab[i] < arr_tab[best]))
               best = i;
         end
         return best;
      endfunction

      function void jump_to_arrival(bit only_new);
         bit          found;
         logic [15:0] t;
         found = 0;
         t     = '0;
         for (int i = 0; i < job_count; i++) begin
            if (left_tab[i] == 0 || (only_new && admitted[i])) continue;
            if (!found || arr_tab[i] < t) begin
               t     = arr_tab[i];
               found = 1;
            end
         end
         if (found && 24'(t) > now_t) now_t = 24'(t);
      endfunction

      function void rr_push(int i);
         if (rr_used >= NJOBS) return;
         rr_q[rr_tail] = i;
         rr_tail = (rr_tail + 1) % NJOBS;
         rr_used++;
      endfunction

      function void admit_arrivals();
         int i;
         for (int n = 0; n < NJOBS; n++) begin
            i = pick_job(POL_FCFS, 1);
            if (i < 0) break;
            admitted[i] = 1;
            rr_push(i);
         end
      endfunction

      function void drop_done_heads();
         while (rr_used > 0 &&
                (rr_q[rr_head] >= job_count || left_tab[rr_q[rr_head]] == 0)) begin
            rr_head = (rr_head + 1) % NJOBS;
            rr_used--;
         end
      endfunction

      // next slice for a dispatch command
      function slice_beat_type predict_slice();
         slice_beat_type b;
         logic [2:0]     pol;
         int             idx;
         logic [15:0]    len;
         logic [23:0]    tat;
         b   = '{default: '0};
         pol = (policy > POL_SRTF) ? POL_FCFS : policy;
         if (done_count >= job_count) begin
            b.status = STS_DONE;
            return b;
         end
         if (pol == POL_RR) begin
            admit_arrivals();
            drop_done_heads();
            if (rr_used == 0) begin
               jump_to_arrival(1);
               admit_arrivals();
               drop_done_heads();
            end
            if (rr_used == 0) begin
               b.status = STS_DONE;
               return b;
            end
            idx     = rr_q[rr_head];
            rr_head = (rr_head + 1) % NJOBS;
            rr_used--;
            len = (quantum == 0) ? 16'd1 : quantum;
            if (len > left_tab[idx]) len = left_tab[idx];
         end else begin
            idx = pick_job(pol, 0);
            if (idx < 0) begin
               jump_to_arrival(0);
               idx = pick_job(pol, 0);
            end
            if (idx < 0) begin
               b.status = STS_DONE;
               return b;
            end
            len = (pol == POL_SRTF) ? 16'd1 : left_tab[idx];
         end
         b.slice_start = now_t;
         if (!started[idx]) begin
            resp_tab[idx] = now_t - 24'(arr_tab[idx]);
            started[idx]  = 1;
         end
         now_t = now_t + 24'(len);
         left_tab[idx] = left_tab[idx] - len;
         if (pol == POL_RR) begin
            admit_arrivals();
            if (left_tab[idx] > 0) rr_push(idx);
         end
         b.status       = STS_SLICE;
         b.proc_index   = 4'(idx);
         b.slice_length = len;
         if (left_tab[idx] == 0) begin
            tat             = now_t - 24'(arr_tab[idx]);
            done_count++;
            b.finished        = 1;
            b.response_time   = resp_tab[idx];
            b.turnaround_time = tat;
            b.waiting_time    = tat - 24'(burst_tab[idx]);
         end
         return b;
      endfunction

      function void note_command(logic [1:0] op, logic [15:0] a, logic [15:0] bt,
                                 logic [7:0] p);
         slice_beat_type b;
         b = '{default: '0};
         case (op)
            OP_LOAD: begin
               if (job_count >= NJOBS) b.status = STS_FULL;
               else begin
                  arr_tab[job_count]   = a;
                  burst_tab[job_count] = (bt == 0) ? 16'd1 : bt;
                  prio_tab[job_count]  = p;
                  job_count++;
                  clear_progress();
               end
            end
            OP_DISPATCH: b = predict_slice();
            OP_REWIND:   clear_progress();
            default:     ;
         endcase
         expected_beats = {expected_beats, b};
      endfunction

      function void check_beat(slice_beat_type got);
         slice_beat_type exp;
         if (expected_beats.size() == 0) begin
            $display("%0t: response beat with none expected, status %0d", $time, got.status);
            errors++;
            return;
         end
         exp = expected_beats.pop_front();
         if (got.status !== exp.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
            errors++;
         end
         if (got.proc_index !== exp.proc_index) begin
            $display("%0t: proc_index exp %0d got %0d", $time, exp.proc_index, got.proc_index);
            errors++;
         end
         if (got.slice_start !== exp.slice_start) begin
            $display("%0t: slice_start exp %0d got %0d", $time, exp.slice_start,
                     got.slice_start);
            errors++;
         end
         if (got.slice_length !== exp.slice_length) begin
            $display("%0t: slice_length exp %0d got %0d", $time, exp.slice_length,
                     got.slice_length);
            errors++;
         end
         if (got.finished !== exp.finished) begin
            $display("%0t: finished exp %0d got %0d", $time, exp.finished, got.finished);
            errors++;
         end
         if (got.response_time !== exp.response_time) begin
            $display("%0t: response_time exp %0d got %0d", $time, exp.response_time,
                     got.response_time);
            errors++;
         end
         if (got.turnaround_time !== exp.turnaround_time) begin
            $display("%0t: turnaround_time exp %0d got %0d", $time, exp.turnaround_time,
                     got.turnaround_time);
            errors++;
         end
         if (got.waiting_time !== exp.waiting_time) begin
            $display("%0t: waiting_time exp %0d got %0d", $time, exp.waiting_time,
                     got.waiting_time);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [15:0] req_arrival_time = '0;
   logic [15:0] req_burst_time = '0;
   logic [7:0]  req_prio_level = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_proc_index;
   time_type    rsp_slice_start;
   logic [15:0] rsp_slice_length;
   logic        rsp_finished;
   time_type    rsp_response_time;
   time_type    rsp_turnaround_time;
   time_type    rsp_waiting_time;
   logic        csr_wr_en = 0;
   logic        csr_index = REG_POLICY;
   logic [15:0] csr_wr_data = '0;

   dispatch_scoreboard sb = new();

   // idling percentages for each side, and a long receiver hold-off
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_cycles = 0;
   int stall_count = 0;
   int cmd_total   = 0;

   always #4 clock = ~clock;

   task_dispatch_scheduler_top dut (.*);

   // receiver: check every accepted beat, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_beat('{rsp_status, rsp_proc_index, rsp_slice_start, rsp_slice_length,
                         rsp_finished, rsp_response_time, rsp_turnaround_time,
                         rsp_waiting_time});
      if (reset) rsp_ready <= 0;
      else if (hold_cycles > 0) begin
         // long hold-off so the block fills up and backs up its input
         rsp_ready <= 0;
         hold_cycles--;
      end else rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // offer one command beat and hold it until taken
   task automatic send_cmd(logic [1:0] op, logic [15:0] a, logic [15:0] bt, logic [7:0] p);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1;
      req_opcode       <= op;
      req_arrival_time <= a;
      req_burst_time   <= bt;
      req_prio_level   <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_command(op, a, bt, p);
      cmd_total++;
   endtask

   // drain all responses before touching the registers
   task automatic wait_idle();
      req_valid <= 0;
      @(posedge clock);
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] data);
      csr_wr_en   <= 1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 0;
      if (idx == REG_POLICY) sb.policy = data[2:0];
      else sb.quantum = data;
      @(posedge clock);
   endtask

   task automatic load_random_job();
      logic [15:0] a, bt;
      a  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      bt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      send_cmd(OP_LOAD, a, bt, 8'($urandom));
   endtask

   task automatic dispatch_dummy();
      send_cmd(OP_DISPATCH, 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   // one phase: new settings, maybe new jobs, then a dispatch run
   task automatic run_round();
      int n;
      int r;
      wait_idle();
      write_reg(REG_POLICY, 16'($urandom_range(0, 7)));
      case ($urandom_range(5))
         0: write_reg(REG_QUANTUM, 16'd0);
         1: write_reg(REG_QUANTUM, 16'hFFFF);
         2: write_reg(REG_QUANTUM, 16'($urandom));
         default: write_reg(REG_QUANTUM, 16'($urandom_range(1, 5)));
      endcase
      if (sb.job_count < 16 || $urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 2)) load_random_job();
      end else send_cmd(OP_REWIND, 16'($urandom), 16'($urandom), 8'($urandom));
      n = 0;
      while (n < 40 && (sb.done_count < sb.job_count || $urandom_range(2) == 0)) begin
         r = $urandom_range(99);
         // mostly well-formed dispatch runs, a little noise
         if (r < 3) send_cmd(2'd3, 16'($urandom), 16'($urandom), 8'($urandom));
         else if (r < 5) send_cmd(OP_REWIND, 16'($urandom), 16'($urandom), 8'($urandom));
         else if (r < 7) load_random_job();
         else dispatch_dummy();
         n++;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, unused opcode, extremes of a load
      dispatch_dummy();
      send_cmd(2'd3, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_cmd(OP_REWIND, 16'h0, 16'h0, 8'h0);
      send_cmd(OP_LOAD, 16'd0, 16'd0, 8'd0);
      send_cmd(OP_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_cmd(OP_LOAD, 16'd5, 16'd3, 8'd128);
      // fcfs with an idle jump to the late arrival, then all done
      repeat (4) dispatch_dummy();
      // round robin with zero quantum
      wait_idle();
      write_reg(REG_POLICY, {13'd0, POL_RR});
      write_reg(REG_QUANTUM, 16'd0);
      send_cmd(OP_REWIND, 16'd0, 16'd0, 8'd0);
      repeat (4) dispatch_dummy();
      // srtf, then an unused policy code
      wait_idle();
      write_reg(REG_POLICY, {13'd0, POL_SRTF});
      repeat (3) dispatch_dummy();
      wait_idle();
      write_reg(REG_POLICY, 16'd7);
      send_cmd(OP_REWIND, 16'd0, 16'd0, 8'd0);
      repeat (3) dispatch_dummy();

      // random: sender lightly idle, receiver heavily, with one long hold-off
      tx_idle_pct = 12;
      rx_idle_pct = 67;
      wait_idle();
      @(negedge clock) hold_cycles = 300;
      while (cmd_total < 300) run_round();
      tx_idle_pct = 67;
      rx_idle_pct = 12;
      while (cmd_total < 560) run_round();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (cmd_total < 820) run_round();

      wait_idle();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.expected_beats.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

// File: filelist.f
rtl/tds_pkg.sv
rtl/tds_ram.sv
rtl/task_dispatch_scheduler_top.sv
test/task_dispatch_scheduler_top_test.sv
